// ===== src/clnc_pkg.sv =====
`default_nettype none

package clnc_pkg;

    // Configuration port geometry.
    localparam int unsigned NUM_CFG   = 5;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CMD_W     = 8;
    localparam int unsigned NIBBLE_W  = 4;
    localparam int unsigned STEP_W    = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_SET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_ROW     = 3'd4;

    // Reset values of the configurable init commands.
    localparam logic [CMD_W-1:0] RST_FUNCTION_SET = 8'h28;
    localparam logic [CMD_W-1:0] RST_DISPLAY_ON   = 8'h0C;
    localparam logic [CMD_W-1:0] RST_CLEAR        = 8'h01;
    localparam logic [CMD_W-1:0] RST_ENTRY_MODE   = 8'h06;
    localparam logic [CMD_W-1:0] RST_HOME_ROW     = 8'h80;

    // Fixed first init command (return home, selects the 4-bit bus).
    localparam logic [CMD_W-1:0] FIRST_INIT_CMD = 8'h02;

    // Init sequencer steps.
    localparam logic [STEP_W-1:0] STEP_FIRST        = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FUNCTION_SET = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DISPLAY_ON   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_CLEAR        = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ENTRY_MODE   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_HOME_ROW     = 3'd5;
    localparam logic [STEP_W-1:0] STEP_READY        = 3'd6;

    // Register select levels.
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        PH_HIGH_RISE = 2'd0,
        PH_HIGH_FALL = 2'd1,
        PH_LOW_RISE  = 2'd2,
        PH_LOW_FALL  = 2'd3
    } t_phase;

    typedef logic [NUM_CFG-1:0][CMD_W-1:0] t_cmd_array;

    typedef struct packed {
        logic                accepted;
        logic                reg_select;
        logic [NIBBLE_W-1:0] data_nibble;
        logic                enable_pin;
        logic                ready_res;
        logic                busy_res;
    } t_result;

endpackage

`default_nettype wire

// ===== src/clnc_seq.sv =====
`default_nettype none

module clnc_seq (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  wire                   i_operation,
    input  wire  [7:0]            i_character,
    input  clnc_pkg::t_cmd_array  i_cmds,
    output clnc_pkg::t_result     o_result
);
    import clnc_pkg::*;

    logic [STEP_W-1:0]   r_init_step, n_init_step;
    t_phase              r_phase, n_phase;
    logic                r_pending, n_pending;
    logic [CMD_W-1:0]    r_held_char, n_held_char;
    logic                r_rs_level, n_rs_level;
    logic [NIBBLE_W-1:0] r_nibble_level, n_nibble_level;
    logic                r_en_level, n_en_level;

    logic                init_done;
    logic                drive_en;
    logic [CMD_W-1:0]    init_cmd;
    logic [CMD_W-1:0]    tx_byte;
    logic                byte_done;
    logic                accepted;

    assign init_done = (r_init_step >= STEP_READY);

    always_comb begin
        unique case (r_init_step)
            STEP_FIRST:        init_cmd = FIRST_INIT_CMD;
            STEP_FUNCTION_SET: init_cmd = i_cmds[CFG_FUNCTION_SET];
            STEP_DISPLAY_ON:   init_cmd = i_cmds[CFG_DISPLAY_ON];
            STEP_CLEAR:        init_cmd = i_cmds[CFG_CLEAR];
            STEP_ENTRY_MODE:   init_cmd = i_cmds[CFG_ENTRY_MODE];
            STEP_HOME_ROW:     init_cmd = i_cmds[CFG_HOME_ROW];
            default:           init_cmd = '0;
        endcase
    end

    assign tx_byte  = init_done ? r_held_char : init_cmd;
    assign drive_en = i_step && (t_op'(i_operation) == OP_TICK) && (!init_done || r_pending);

    always_comb begin
        n_init_step    = r_init_step;
        n_phase        = r_phase;
        n_pending      = r_pending;
        n_held_char    = r_held_char;
        n_rs_level     = r_rs_level;
        n_nibble_level = r_nibble_level;
        n_en_level     = r_en_level;
        byte_done      = 1'b0;
        accepted       = 1'b0;

        if (i_step && (t_op'(i_operation) == OP_WRITE) && init_done && !r_pending) begin
            n_pending   = 1'b1;
            n_held_char = i_character;
            accepted    = 1'b1;
        end

        if (drive_en) begin
            unique case (r_phase)
                PH_HIGH_RISE: begin
                    n_rs_level     = init_done ? RS_DATA : RS_COMMAND;
                    n_nibble_level = tx_byte[CMD_W-1 -: NIBBLE_W];
                    n_en_level     = 1'b1;
                    n_phase        = PH_HIGH_FALL;
                end
                PH_HIGH_FALL: begin
                    n_en_level = 1'b0;
                    n_phase    = PH_LOW_RISE;
                end
                PH_LOW_RISE: begin
                    n_nibble_level = tx_byte[NIBBLE_W-1:0];
                    n_en_level     = 1'b1;
                    n_phase        = PH_LOW_FALL;
                end
                PH_LOW_FALL: begin
                    n_en_level = 1'b0;
                    n_phase    = PH_HIGH_RISE;
                    byte_done  = 1'b1;
                end
                default: begin
                    n_phase = PH_HIGH_RISE;
                end
            endcase
        end

        // The last nibble of a byte advances init or clears the pending character.
        if (byte_done) begin
            if (!init_done) begin
                n_init_step = r_init_step + STEP_W'(1);
            end else begin
                n_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_step    <= STEP_FIRST;
            r_phase        <= PH_HIGH_RISE;
            r_pending      <= 1'b0;
            r_held_char    <= '0;
            r_rs_level     <= RS_COMMAND;
            r_nibble_level <= '0;
            r_en_level     <= 1'b0;
        end else begin
            r_init_step    <= n_init_step;
            r_phase        <= n_phase;
            r_pending      <= n_pending;
            r_held_char    <= n_held_char;
            r_rs_level     <= n_rs_level;
            r_nibble_level <= n_nibble_level;
            r_en_level     <= n_en_level;
        end
    end

    // The result reflects the state after this step's update.
    always_comb begin
        o_result.accepted    = accepted;
        o_result.reg_select  = n_rs_level;
        o_result.data_nibble = n_nibble_level;
        o_result.enable_pin  = n_en_level;
        o_result.ready_res   = (n_init_step >= STEP_READY);
        o_result.busy_res    = n_pending;
    end

    // Enable is high exactly in the two fall phases of a byte.
    a_en_follows_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en_level == r_phase[0])
        else $error("enable level out of step with nibble phase");

    // A byte in flight is either an init command or a pending character.
    a_phase_has_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HIGH_RISE) |-> (!init_done || r_pending))
        else $error("nibble phase moved with nothing to send");

    // The init sequencer stops at the ready step.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init_step <= STEP_READY)
        else $error("init step ran past ready");

    // Data register select is only used once init is over.
    a_rs_data_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rs_level == RS_DATA) |-> init_done)
        else $error("data register select during init");

endmodule

`default_nettype wire

// ===== src/char_lcd_nibble_controller.sv =====
`default_nettype none

// Channel    Handshake              Payload
// ---------  ---------------------  ---------------------------------------------
// input      i_valid / o_ready      i_operation, i_character
// output     o_valid / i_ready      o_accepted, o_reg_select, o_data_nibble,
//                                   o_enable_pin, o_ready_res, o_busy_res
// config     i_cfg_we               i_cfg_index, i_cfg_data (no handshake)
//
// Each input beat is handled in the cycle of acceptance: the state update is
// done in that cycle and its result lands in the output register on the same edge.
// A new beat is taken every cycle while the output register is empty or being
// drained, so the rate is one beat per clock, set by the single output stage.
// Reset is synchronous and active low; it restores the default init commands
// and restarts the six-command init sequence from the fixed first command.
// A stall on the output holds o_ready low and freezes the controller state.

module char_lcd_nibble_controller (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire                               i_operation,
    input  wire  [7:0]                        i_character,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic                              o_accepted,
    output logic                              o_reg_select,
    output logic [clnc_pkg::NIBBLE_W-1:0]     o_data_nibble,
    output logic                              o_enable_pin,
    output logic                              o_ready_res,
    output logic                              o_busy_res,
    input  wire                               i_cfg_we,
    input  wire  [clnc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [clnc_pkg::CMD_W-1:0]        i_cfg_data
);
    import clnc_pkg::*;

    t_cmd_array r_cmds;
    t_result    seq_result;
    t_result    r_result;
    logic       r_out_valid, n_out_valid;
    logic       in_beat;

    // The input side is open whenever the output register is free or drains now.
    assign o_ready = !r_out_valid || i_ready;
    assign in_beat = i_valid && o_ready;

    // Configuration registers. Writes to an index past the last register drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmds[CFG_FUNCTION_SET] <= RST_FUNCTION_SET;
            r_cmds[CFG_DISPLAY_ON]   <= RST_DISPLAY_ON;
            r_cmds[CFG_CLEAR]        <= RST_CLEAR;
            r_cmds[CFG_ENTRY_MODE]   <= RST_ENTRY_MODE;
            r_cmds[CFG_HOME_ROW]     <= RST_HOME_ROW;
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(NUM_CFG))) begin
            r_cmds[i_cfg_index] <= i_cfg_data;
        end
    end

    clnc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_beat),
        .i_operation (i_operation),
        .i_character (i_character),
        .i_cmds      (r_cmds),
        .o_result    (seq_result)
    );

    // Output register: loaded on every input beat, held while stalled.
    assign n_out_valid = in_beat || (r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_result <= seq_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_accepted    = r_result.accepted;
    assign o_reg_select  = r_result.reg_select;
    assign o_data_nibble = r_result.data_nibble;
    assign o_enable_pin  = r_result.enable_pin;
    assign o_ready_res   = r_result.ready_res;
    assign o_busy_res    = r_result.busy_res;

    // A taken write request always leaves a pending character behind.
    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (o_busy_res && o_ready_res))
        else $error("accepted request without pending character");

    // Every input beat produces a result beat on the next edge.
    a_beat_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_valid)
        else $error("input beat lost");

    // Once initialization is reported done it stays done.
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ready_res && in_beat) |=> o_ready_res)
        else $error("ready status dropped after init");

endmodule

`default_nettype wire
